### hw/rtl/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;

  // Default datapath width; inputs are masked to it, the result truncated to 32 bits.
  localparam int unsigned OperandWidthDefault = 32;

  // Width of each input and output field on the stream ports.
  localparam int unsigned FieldWidth = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL_ACC,
    ST_MUL_SQR,
    ST_FINISH
  } state_e;

endpackage

### hw/rtl/modular_exponentiation.sv
// Modular exponentiation by right-to-left square-and-multiply on one shared mod-add unit.
//
// Each slave transaction carries base, exponent and modulus and yields exactly one
// master transaction with base^exponent mod modulus. All three operands are masked to
// OPERAND_WIDTH bits (W) before use. The block works on one item at a time and holds
// s_axis_tready low while busy. An item first reduces the base modulo the modulus, one
// bit per cycle, then walks the W exponent bits from the least significant: a set bit
// costs one modular multiplication of the accumulator and every bit costs one modular
// squaring of the base. Both multiplications run bit-serial on the same unit, which
// does one conditional mod-add and one mod-double per cycle. A zero modulus skips the
// arithmetic and returns zero with zero_modulus_error set. A modulus of one returns
// zero. The output register lets a finished result wait for m_axis_tready; the next
// item is accepted as soon as its result has been handed over to that register.
module modular_exponentiation #(
  parameter int unsigned OPERAND_WIDTH = modexp_pkg::OperandWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] base_value, [63:32] exponent_value, [95:64] modulus_value
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] power_result
  output logic [31:0] m_axis_tdata,
  // [0] zero_modulus_error
  output logic        m_axis_tuser
);

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = $clog2(W);
  localparam int unsigned FW   = modexp_pkg::FieldWidth;
  localparam logic [CntW-1:0] CntLast = CntW'(W - 1);

  // Control state
  modexp_pkg::state_e state_q, state_d;
  logic               out_valid_q;
  logic               s_fire;
  logic               load_out;
  logic               cnt_last;
  logic               ebit_last;

  // Payload registers
  logic [W-1:0]    mod_q;      // modulus
  logic [W-1:0]    base_q;     // running base, reduced below the modulus
  logic [W-1:0]    exp_q;      // exponent, shifted right once per exponent bit
  logic [W-1:0]    acc_q;      // running power
  logic [W-1:0]    prod_q;     // product under construction
  logic [W-1:0]    addend_q;   // doubling chain of the multiplicand
  logic [W-1:0]    y_q;        // multiplier bits, also the base bits during reduction
  logic [CntW-1:0] cnt_q;      // step within a reduction or multiplication
  logic [CntW-1:0] ebit_q;     // exponent bit under work
  logic            err_q;
  logic [FW-1:0]   out_data_q;
  logic            out_err_q;

  // Masked input operands
  logic [W-1:0] base_in;
  logic [W-1:0] exp_in;
  logic [W-1:0] mod_in;

  // Shared unit: one conditional mod-add and one mod-double with carry-in
  logic [W:0]   add_sum;
  logic [W-1:0] add_red;
  logic [W-1:0] dbl_src;
  logic         dbl_cin;
  logic [W:0]   dbl_sum;
  logic [W-1:0] dbl_red;
  logic [W-1:0] prod_nx;

  assign base_in = W'(s_axis_tdata[FW-1:0]);
  assign exp_in  = W'(s_axis_tdata[2*FW-1:FW]);
  assign mod_in  = W'(s_axis_tdata[3*FW-1:2*FW]);

  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign cnt_last  = (cnt_q == CntLast);
  assign ebit_last = (ebit_q == CntLast);

  // Operands stay below the modulus, so each sum is below twice the modulus
  // and a single compare-and-subtract brings it back into range.
  assign add_sum = {1'b0, prod_q} + {1'b0, addend_q};
  assign add_red = (add_sum >= {1'b0, mod_q}) ? W'(add_sum - {1'b0, mod_q}) : W'(add_sum);

  // During reduction the double path shifts in the next base bit from the top.
  assign dbl_src = (state_q == modexp_pkg::ST_REDUCE) ? base_q : addend_q;
  assign dbl_cin = (state_q == modexp_pkg::ST_REDUCE) ? y_q[W-1] : 1'b0;
  assign dbl_sum = {dbl_src, dbl_cin};
  assign dbl_red = (dbl_sum >= {1'b0, mod_q}) ? W'(dbl_sum - {1'b0, mod_q}) : W'(dbl_sum);

  // Product after this step: add the multiplicand when the multiplier bit is set
  assign prod_nx = y_q[0] ? add_red : prod_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      modexp_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_d = (mod_in == '0) ? modexp_pkg::ST_FINISH : modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (cnt_last) begin
          state_d = exp_q[0] ? modexp_pkg::ST_MUL_ACC : modexp_pkg::ST_MUL_SQR;
        end
      end
      modexp_pkg::ST_MUL_ACC: begin
        if (cnt_last) begin
          state_d = modexp_pkg::ST_MUL_SQR;
        end
      end
      modexp_pkg::ST_MUL_SQR: begin
        if (cnt_last) begin
          if (ebit_last) begin
            state_d = modexp_pkg::ST_FINISH;
          end else begin
            // exp_q shifts at this edge, so the next bit is bit one
            state_d = exp_q[1] ? modexp_pkg::ST_MUL_ACC : modexp_pkg::ST_MUL_SQR;
          end
        end
      end
      modexp_pkg::ST_FINISH: begin
        if (load_out) begin
          state_d = modexp_pkg::ST_IDLE;
        end
      end
      default: state_d = modexp_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = (state_q == modexp_pkg::ST_IDLE);
    load_out      = (state_q == modexp_pkg::ST_FINISH) && (!out_valid_q || m_axis_tready);
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= modexp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register: hold a result until the master side takes it
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= FW'(acc_q);
      out_err_q  <= err_q;
    end
  end

  // Datapath sequencing
  always_ff @(posedge clk_i) begin
    case (state_q)
      modexp_pkg::ST_IDLE: begin
        if (s_fire) begin
          mod_q  <= mod_in;
          exp_q  <= exp_in;
          y_q    <= base_in;
          base_q <= '0;
          cnt_q  <= '0;
          ebit_q <= '0;
          err_q  <= (mod_in == '0);
          // 1 mod m: zero for a modulus of one, and zero result on error
          acc_q  <= (mod_in > W'(1)) ? W'(1) : '0;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        base_q <= dbl_red;
        y_q    <= y_q << 1;
        cnt_q  <= cnt_q + CntW'(1);
        if (cnt_last) begin
          cnt_q  <= '0;
          prod_q <= '0;
          y_q    <= dbl_red;
          // the accumulator multiply feeds the accumulator, the square the base
          addend_q <= exp_q[0] ? acc_q : dbl_red;
        end
      end
      modexp_pkg::ST_MUL_ACC: begin
        prod_q   <= prod_nx;
        addend_q <= dbl_red;
        y_q      <= y_q >> 1;
        cnt_q    <= cnt_q + CntW'(1);
        if (cnt_last) begin
          acc_q    <= prod_nx;
          cnt_q    <= '0;
          prod_q   <= '0;
          addend_q <= base_q;
          y_q      <= base_q;
        end
      end
      modexp_pkg::ST_MUL_SQR: begin
        prod_q   <= prod_nx;
        addend_q <= dbl_red;
        y_q      <= y_q >> 1;
        cnt_q    <= cnt_q + CntW'(1);
        if (cnt_last) begin
          base_q   <= prod_nx;
          exp_q    <= exp_q >> 1;
          ebit_q   <= ebit_q + CntW'(1);
          cnt_q    <= '0;
          prod_q   <= '0;
          y_q      <= prod_nx;
          addend_q <= exp_q[1] ? acc_q : prod_nx;
        end
      end
      default: begin
        // hold everything while the result waits for the output register
      end
    endcase
  end

  // A fresh item drops ready on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("ready stayed high after an accepted transaction");

  // An error result always carries a zero power
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("zero modulus result is not zero");

  // The arithmetic only runs on a nonzero modulus with reduced operands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == modexp_pkg::ST_MUL_ACC || state_q == modexp_pkg::ST_MUL_SQR)
      |-> (mod_q != '0 && acc_q < mod_q && base_q < mod_q && addend_q < mod_q))
    else $error("multiplier operand not reduced below the modulus");

  // A new result only enters the output register when the previous one is gone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && out_valid_q) |-> m_axis_tready)
    else $error("output register overwritten before handover");

endmodule

### tb/sv/testbench.sv
// Self-checking stream testbench for the modular exponentiation block.
module testbench;

  // Give up long after the slowest legal run: every item with an all-ones
  // exponent, plus stalls on both sides and the long receiver hold-off.
  localparam int CycleLimit = 3_000_000;
  localparam int DrainCycles = 2200;
  localparam int HoldOffCycles = 5000;
  localparam int HoldOffAfter = 40;
  localparam int IdlePercent = 25;
  localparam int CalmFirst = 120;
  localparam int CalmLast = 180;
  localparam int RandomItems = 250;
  localparam int ReportLimit = 10;

  // Base sits in the lowest bits, matching the slave tdata layout.
  typedef struct packed {
    logic [modexp_pkg::FieldWidth-1:0] modulus;
    logic [modexp_pkg::FieldWidth-1:0] exponent;
    logic [modexp_pkg::FieldWidth-1:0] base;
  } operands_t;

  typedef struct packed {
    logic [modexp_pkg::FieldWidth-1:0] power;
    logic                              zero_mod;
  } power_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  operands_t pending_operands[$];
  power_t    expected_powers[$];
  int        total_items = 0;
  int        accepted_cnt = 0;
  int        results_cnt = 0;
  int        mismatch_cnt = 0;
  int        zero_mod_cnt = 0;
  int        backed_up_cycles = 0;
  int        cycle_cnt = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  modular_exponentiation u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Right-to-left square-and-multiply. Operands stay below 2^32, so every
  // product fits in 64 bits and a plain remainder reduces it exactly.
  function automatic power_t predict_power(operands_t op);
    logic [63:0] modulus;
    logic [63:0] square;
    logic [63:0] acc;
    power_t      res;
    res = '0;
    if (op.modulus == '0) begin
      res.zero_mod = 1'b1;
      return res;
    end
    modulus = 64'(op.modulus);
    square = 64'(op.base) % modulus;
    acc = 64'd1 % modulus;
    for (int i = 0; i < modexp_pkg::FieldWidth; i++) begin
      if (op.exponent[i]) acc = (acc * square) % modulus;
      square = (square * square) % modulus;
    end
    res.power = acc[modexp_pkg::FieldWidth-1:0];
    return res;
  endfunction

  task automatic queue_operands(input logic [31:0] base, input logic [31:0] exponent,
                                input logic [31:0] modulus);
    operands_t op;
    op.base = base;
    op.exponent = exponent;
    op.modulus = modulus;
    pending_operands.push_back(op);
  endtask

  // Mix moduli so the error flag, the trivial modulus, tiny rings and
  // full-width rings all show up; bias bases and exponents toward edges.
  task automatic queue_random_operands();
    logic [31:0] modulus;
    logic [31:0] base;
    logic [31:0] exponent;
    int          pick;
    pick = $urandom_range(19);
    if (pick == 0) modulus = '0;
    else if (pick == 1) modulus = 32'd1;
    else if (pick <= 3) modulus = $urandom_range(255, 2);
    else if (pick == 4) modulus = $urandom | 32'hFFFF_0000;
    else modulus = $urandom;
    pick = $urandom_range(19);
    if (pick == 0) base = '0;
    else if (pick == 1) base = modulus;
    else if (pick == 2) base = modulus - 32'd1;
    else if (pick == 3) base = $urandom_range(15);
    else base = $urandom;
    pick = $urandom_range(19);
    if (pick <= 1) exponent = $urandom_range(15);
    else if (pick == 2) exponent = '1;
    else exponent = $urandom;
    queue_operands(base, exponent, modulus);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatch_cnt < ReportLimit)
      $display("mismatch at result %0d: %s expected %h, got %h", results_cnt, what, want, got);
    mismatch_cnt++;
  endtask

  // Driver: advance to the next pending item once the current transaction
  // is taken; idle at random except inside the calm window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_operands.size() > 0 &&
          ((accepted_cnt >= CalmFirst && accepted_cnt < CalmLast) ||
           $urandom_range(99) >= IdlePercent)) begin
        s_axis_tdata  <= pending_operands.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Hold-off: once, drop tready for long enough that a finished result sits
  // in the output register and the next item finishes behind it, so the
  // block must stall its input while the driver keeps offering.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HoldOffAfter) begin
      hold_left <= HoldOffCycles;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stall at random outside the calm window and the hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) &&
                       ((results_cnt >= CalmFirst && results_cnt < CalmLast) ||
                        $urandom_range(99) >= IdlePercent);
    end
  end

  // Monitor: predict on each slave transaction, check each master
  // transaction against the oldest prediction.
  always @(posedge clk_i) begin
    power_t    want;
    operands_t op;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        op = s_axis_tdata;
        expected_powers.push_back(predict_power(op));
        accepted_cnt <= accepted_cnt + 1;
        if (op.modulus == '0) zero_mod_cnt <= zero_mod_cnt + 1;
      end
      if (s_axis_tvalid && !s_axis_tready && m_axis_tvalid && !m_axis_tready)
        backed_up_cycles <= backed_up_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_powers.size() == 0) begin
          report_mismatch("unexpected transaction, data", '0, m_axis_tdata);
        end else begin
          want = expected_powers.pop_front();
          if (m_axis_tdata !== want.power)
            report_mismatch("power_result", want.power, m_axis_tdata);
          if (m_axis_tuser !== want.zero_mod)
            report_mismatch("zero_modulus_error", 32'(want.zero_mod), 32'(m_axis_tuser));
        end
        results_cnt <= results_cnt + 1;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, expected_powers.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // Directed: error flag, trivial modulus, zero exponent and zero base,
    // then field extremes and a few values with known answers.
    queue_operands(32'd5, 32'd3, 32'd0);
    queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    queue_operands(32'd0, 32'd0, 32'd0);
    queue_operands(32'd123, 32'd45, 32'd1);
    queue_operands(32'd0, 32'hFFFF_FFFF, 32'd1);
    queue_operands(32'd1, 32'd0, 32'd1);
    queue_operands(32'd7, 32'd0, 32'd13);
    queue_operands(32'd0, 32'd0, 32'd13);
    queue_operands(32'd0, 32'd9, 32'd13);
    queue_operands(32'd4, 32'd13, 32'd497);
    queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_operands(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    queue_operands(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFB);
    queue_operands(32'hFFFF_FFFA, 32'd2, 32'hFFFF_FFFB);
    queue_operands(32'd2, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
    queue_operands(32'd3, 32'hFFFF_FFFF, 32'd2);
    queue_operands(32'd97, 32'd5, 32'd97);
    queue_operands(32'hDEAD_BEEF, 32'h8000_0000, 32'h8000_0000);
    queue_operands(32'h1234_5678, 32'd1, 32'h7FFF_FFFF);
    queue_operands(32'd2, 32'd31, 32'hFFFF_FFFF);
    repeat (RandomItems) queue_random_operands();
    total_items = pending_operands.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every item to be taken and every result to arrive, then
    // leave room for any stray extra transaction.
    do @(negedge clk_i);
    while (accepted_cnt != total_items || expected_powers.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("ran %0d items, %0d with a zero modulus, %0d results checked",
             total_items, zero_mod_cnt, results_cnt);
    $display("input stalled behind a full output for %0d cycles, %0d mismatches",
             backed_up_cycles, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
